[hdl/spag_pkg.sv]
package spag_pkg;

   localparam int SLOT_W         = 7;
   localparam int COORD_W        = 16;
   localparam int SCROLL_W       = 16;
   localparam int LAYERS         = 3;
   localparam int DEF_SPRITE_SLOTS = 80;
   localparam int CSR_ADDR_W     = 5;
   localparam int CSR_DATA_W     = 32;
   localparam int REQ_DATA_W     = 104;
   localparam int RSP_DATA_W     = 56;

   localparam logic [COORD_W-1:0] SCREEN_BIAS = 16'd128;
   localparam logic [COORD_W-1:0] WRAP_SPAN   = 16'd2048;
   localparam logic [COORD_W-1:0] WRAP_LOW    = 16'd256;
   localparam logic [COORD_W-1:0] WRAP_HIGH   = 16'd1792;

   typedef enum logic [1:0] {
      LAYER_ABS = 2'd0,
      LAYER_A   = 2'd1,
      LAYER_B   = 2'd2,
      LAYER_C   = 2'd3
   } layer_type;

   typedef enum logic [2:0] {
      REG_A_SCROLL_X = 3'd0,
      REG_B_SCROLL_X = 3'd1,
      REG_C_SCROLL_X = 3'd2,
      REG_A_SCROLL_Y = 3'd3,
      REG_B_SCROLL_Y = 3'd4,
      REG_C_SCROLL_Y = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [LAYERS-1:0][SCROLL_W-1:0] sx;
      logic [LAYERS-1:0][SCROLL_W-1:0] sy;
   } scroll_type;

   // first declared member sits in the highest bits
   typedef struct packed {
      logic                     pad;
      logic [7:0]               piece_height;
      logic [7:0]               piece_width;
      logic [7:0]               piece_attr;
      logic signed [COORD_W-1:0] piece_yoff;
      logic signed [COORD_W-1:0] piece_xoff;
      logic [9:0]               piece_index;
      logic                     force_priority;
      logic [1:0]               obj_flip;
      logic [1:0]               layer;
      logic signed [COORD_W-1:0] obj_y;
      logic signed [COORD_W-1:0] obj_x;
   } piece_type;

   typedef struct packed {
      logic [3:0]               pad;
      logic                     sprite_priority;
      logic [1:0]               sprite_flip;
      logic [SLOT_W-1:0]        sprite_slot;
      logic [9:0]               sprite_index;
      logic signed [COORD_W-1:0] sprite_y;
      logic signed [COORD_W-1:0] sprite_x;
   } sprite_type;

endpackage

[hdl/spag_csr.sv]
module spag_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spag_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [spag_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [spag_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output spag_pkg::scroll_type               scroll
);

   spag_pkg::scroll_type  scroll_ff;
   spag_pkg::scroll_type  scroll_in;
   spag_pkg::reg_idx_type idx;
   logic [spag_pkg::SCROLL_W-1:0] wdata;
   logic [spag_pkg::SCROLL_W-1:0] rdata;
   logic                          wr;

   assign csr_pready = 1'b1;
   assign idx        = spag_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign wdata      = csr_pwdata[spag_pkg::SCROLL_W-1:0];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      scroll_in = scroll_ff;
      if (wr) begin
         case (idx)
            spag_pkg::REG_A_SCROLL_X: scroll_in.sx[0] = wdata;
            spag_pkg::REG_B_SCROLL_X: scroll_in.sx[1] = wdata;
            spag_pkg::REG_C_SCROLL_X: scroll_in.sx[2] = wdata;
            spag_pkg::REG_A_SCROLL_Y: scroll_in.sy[0] = wdata;
            spag_pkg::REG_B_SCROLL_Y: scroll_in.sy[1] = wdata;
            spag_pkg::REG_C_SCROLL_Y: scroll_in.sy[2] = wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         spag_pkg::REG_A_SCROLL_X: rdata = scroll_ff.sx[0];
         spag_pkg::REG_B_SCROLL_X: rdata = scroll_ff.sx[1];
         spag_pkg::REG_C_SCROLL_X: rdata = scroll_ff.sx[2];
         spag_pkg::REG_A_SCROLL_Y: rdata = scroll_ff.sy[0];
         spag_pkg::REG_B_SCROLL_Y: rdata = scroll_ff.sy[1];
         spag_pkg::REG_C_SCROLL_Y: rdata = scroll_ff.sy[2];
         default:                  rdata = '0;
      endcase
   end

   assign csr_prdata = {{(spag_pkg::CSR_DATA_W-spag_pkg::SCROLL_W){1'b0}}, rdata};
   assign scroll     = scroll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scroll_ff <= '0;
      end else begin
         scroll_ff <= scroll_in;
      end
   end

endmodule

[hdl/spag_pos.sv]
module spag_pos (
   input  spag_pkg::piece_type                piece,
   input  spag_pkg::scroll_type               scroll,
   input  logic [spag_pkg::SLOT_W-1:0]        slot,
   output spag_pkg::sprite_type               sprite
);

   logic [spag_pkg::COORD_W-1:0] sx;
   logic [spag_pkg::COORD_W-1:0] sy;
   logic [spag_pkg::COORD_W-1:0] oy;
   logic [spag_pkg::COORD_W-1:0] wy;
   logic [spag_pkg::COORD_W-1:0] bx;
   logic [spag_pkg::COORD_W-1:0] by;
   logic [spag_pkg::COORD_W-1:0] px;
   logic [spag_pkg::COORD_W-1:0] py;

   always_comb begin
      case (spag_pkg::layer_type'(piece.layer))
         spag_pkg::LAYER_A: begin
            sx = scroll.sx[0];
            sy = scroll.sy[0];
         end
         spag_pkg::LAYER_B: begin
            sx = scroll.sx[1];
            sy = scroll.sy[1];
         end
         spag_pkg::LAYER_C: begin
            sx = scroll.sx[2];
            sy = scroll.sy[2];
         end
         default: begin
            sx = '0;
            sy = '0;
         end
      endcase
   end

   // wrap vertical coordinate near top and bottom of the map
   always_comb begin
      oy = piece.obj_y;
      wy = oy;
      if (sy < spag_pkg::WRAP_LOW) begin
         if (oy >= spag_pkg::WRAP_SPAN) wy = oy - spag_pkg::WRAP_SPAN;
      end else if (sy >= spag_pkg::WRAP_HIGH) begin
         if (oy < spag_pkg::WRAP_LOW) wy = oy + spag_pkg::WRAP_SPAN;
      end
   end

   always_comb begin
      if (spag_pkg::layer_type'(piece.layer) == spag_pkg::LAYER_ABS) begin
         bx = piece.obj_x;
         by = piece.obj_y;
      end else begin
         bx = piece.obj_x - sx + spag_pkg::SCREEN_BIAS;
         by = wy - sy + spag_pkg::SCREEN_BIAS;
      end
   end

   always_comb begin
      if (piece.obj_flip[0]) begin
         px = bx - piece.piece_xoff - {8'd0, piece.piece_width};
      end else begin
         px = bx + piece.piece_xoff;
      end
      if (piece.obj_flip[1]) begin
         py = by - piece.piece_yoff - {8'd0, piece.piece_height};
      end else begin
         py = by + piece.piece_yoff;
      end
   end

   always_comb begin
      sprite                 = '0;
      sprite.sprite_x        = px;
      sprite.sprite_y        = py;
      sprite.sprite_index    = piece.piece_index;
      sprite.sprite_slot     = slot;
      sprite.sprite_flip     = piece.obj_flip ^ {piece.piece_attr[4], piece.piece_attr[3]};
      sprite.sprite_priority = piece.force_priority | piece.piece_attr[7];
   end

endmodule

[hdl/sprite_piece_attribute_gen_top.sv]
// Sprite piece attribute generator. Takes one sprite piece per transaction on the req_ side
// (frame start flag on req_tuser) and returns its screen position, bitmap index, hardware
// slot, flip and priority on the rsp_ side. A new piece is taken every cycle while rsp_tready
// stays high; each accepted piece passes through the input register, and its result is then
// registered in the output register and shown on rsp_. A stalled result holds the input
// register and with it req_tready. The slot counter clears on a frame start
// piece and advances once per result. Empty pieces and pieces arriving after SPRITE_SLOTS
// slots are used give no result. Scroll registers sit on the csr_ port at byte addresses 0 to
// 20 and may only be written while no piece is in flight.
module sprite_piece_attribute_gen_top #(
   parameter int SPRITE_SLOTS = spag_pkg::DEF_SPRITE_SLOTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // obj_x, obj_y, layer, obj_flip, force_priority, piece_index, piece_xoff,
   // piece_yoff, piece_attr, piece_width, piece_height, zero pad
   input  logic [spag_pkg::REQ_DATA_W-1:0]    req_tdata,
   // frame_start
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // sprite_x, sprite_y, sprite_index, sprite_slot, sprite_flip, sprite_priority, zero pad
   output logic [spag_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [spag_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [spag_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [spag_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   localparam logic [spag_pkg::SLOT_W-1:0] SLOT_LIMIT = spag_pkg::SLOT_W'(SPRITE_SLOTS);

   spag_pkg::scroll_type          scroll;
   spag_pkg::piece_type           piece_ff;
   spag_pkg::piece_type           piece_in;
   logic                          frame_ff;
   logic                          frame_in;
   logic                          in_valid_ff;
   logic                          in_valid_in;
   spag_pkg::sprite_type          sprite;
   spag_pkg::sprite_type          out_ff;
   spag_pkg::sprite_type          out_in;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [spag_pkg::SLOT_W-1:0]   slot_ff;
   logic [spag_pkg::SLOT_W-1:0]   slot_in;
   logic [spag_pkg::SLOT_W-1:0]   base_slot;
   logic                          out_open;
   logic                          advance;
   logic                          emit;
   logic                          take;

   spag_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .scroll      (scroll)
   );

   spag_pos u_pos (
      .piece  (piece_ff),
      .scroll (scroll),
      .slot   (base_slot),
      .sprite (sprite)
   );

   assign out_open   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_open;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign base_slot  = frame_ff ? '0 : slot_ff;
   assign emit       = (piece_ff.piece_index != '0) && (base_slot < SLOT_LIMIT);

   always_comb begin
      in_valid_in = in_valid_ff;
      piece_in    = piece_ff;
      frame_in    = frame_ff;
      if (req_tready) in_valid_in = req_tvalid;
      if (take) begin
         piece_in = spag_pkg::piece_type'(req_tdata);
         frame_in = req_tuser;
      end
   end

   always_comb begin
      slot_in      = slot_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_open) out_valid_in = advance && emit;
      if (advance) begin
         slot_in = emit ? base_slot + 1'b1 : base_slot;
         if (emit) out_in = sprite;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         slot_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      piece_ff <= piece_in;
      frame_ff <= frame_in;
      out_ff   <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

[hdl/spag_chk.sv]
module spag_chk #(
   parameter int SPRITE_SLOTS = spag_pkg::DEF_SPRITE_SLOTS
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [spag_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [spag_pkg::SLOT_W-1:0] SLOT_LIMIT = spag_pkg::SLOT_W'(SPRITE_SLOTS);

   spag_pkg::sprite_type rsp;
   assign rsp = spag_pkg::sprite_type'(rsp_tdata);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.sprite_slot < SLOT_LIMIT)
      else $error("slot beyond sprite count");

   a_no_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.sprite_index != '0)
      else $error("result for empty piece");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("pipeline not empty after reset");

endmodule

bind sprite_piece_attribute_gen_top spag_chk #(.SPRITE_SLOTS(SPRITE_SLOTS)) u_spag_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
